### sv/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the 6-bit to ASCII alphabet map for the
// streaming base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [6:0] PAD_CHAR = 7'd61;

	// byte position inside a 3-byte group
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	// one queued item: up to four characters ready to send
	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [1:0]      n_last;
		logic            fin;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [6:0] enc(input logic [5:0] v);
		logic [6:0] w;
		logic [6:0] r;
		w = {1'b0, v};
		if (v < 6'd26)
			r = w + 7'd65;
		else if (v < 6'd52)
			r = w + 7'd71;
		else if (v < 6'd62)
			r = w - 7'd4;
		else if (v == 6'd62)
			r = 7'd43;
		else
			r = 7'd47;
		return r;
	endfunction

endpackage

### sv/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Takes message bytes, tracks group phase and leftover bits, and builds one
// queue entry per byte holding every character that byte causes.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  b64e_pkg::qstat_t  qstat,
	output logic              push,
	output b64e_pkg::job_t    push_job
);
	import b64e_pkg::*;

	phase_t     phase_q;
	phase_t     phase_nxt;
	logic [3:0] left_q;
	logic [3:0] left_nxt;

	assign in_stall = qstat.full;
	assign push     = in_valid & ~in_stall;

	// next state
	always_comb begin
		unique case (phase_q)
			PH_SECOND: begin
				phase_nxt = PH_THIRD;
				left_nxt  = data_byte[3:0];
			end
			PH_THIRD: begin
				phase_nxt = PH_FIRST;
				left_nxt  = 4'd0;
			end
			default: begin
				phase_nxt = PH_SECOND;
				left_nxt  = {2'b00, data_byte[1:0]};
			end
		endcase
		if (final_byte) begin
			phase_nxt = PH_FIRST;
			left_nxt  = 4'd0;
		end
	end

	// outputs
	always_comb begin
		push_job.chars  = {4{PAD_CHAR}};
		push_job.fin    = final_byte;
		push_job.n_last = 2'd0;
		unique case (phase_q)
			PH_SECOND: begin
				push_job.chars[0] = enc({left_q[1:0], data_byte[7:4]});
				push_job.chars[1] = enc({data_byte[3:0], 2'b00});
				push_job.n_last   = final_byte ? 2'd2 : 2'd0;
			end
			PH_THIRD: begin
				push_job.chars[0] = enc({left_q, data_byte[7:6]});
				push_job.chars[1] = enc(data_byte[5:0]);
				push_job.n_last   = 2'd1;
			end
			default: begin
				push_job.chars[0] = enc(data_byte[7:2]);
				push_job.chars[1] = enc({data_byte[1:0], 4'b0000});
				push_job.n_last   = final_byte ? 2'd3 : 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= 4'd0;
		end else if (push) begin
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
		end
	end

endmodule

### sv/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short queue of encoded items between the byte front and character back.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::job_t    push_job,
	input  logic              pop,
	output b64e_pkg::job_t    head_job,
	output b64e_pkg::qstat_t  qstat
);
	import b64e_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head_job    = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### sv/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head entry into the output register one character per cycle
// while not stalled, and retires the entry after its last character.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64e_pkg::job_t    head_job,
	input  b64e_pkg::qstat_t  qstat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        character,
	output logic              run_last,
	output logic              message_end
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       run_last_q;
	logic       msg_end_q;
	logic       load;
	logic       is_last;

	assign load    = ~out_valid_q | ~out_stall;
	assign is_last = (idx_q == head_job.n_last);
	assign pop     = load & ~qstat.empty & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= ~qstat.empty;
			if (!qstat.empty)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			char_q     <= head_job.chars[idx_q];
			run_last_q <= is_last;
			msg_end_q  <= is_last & head_job.fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign run_last    = run_last_q;
	assign message_end = msg_end_q;

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && msg_end_q |-> run_last_q)
		else $error("message end without run last");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> idx_q <= head_job.n_last)
		else $error("character index past entry");

	a_idx_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> idx_q == 2'd0)
		else $error("index left mid entry with empty queue");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && run_last_q)
		else $error("entry retired without its last character");

endmodule

### sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Each accepted byte turns into one to four characters that leave one per
// cycle while the output is not stalled: one for a plain byte in the first
// or second place of a group, two for the third place, and three or four
// for a final byte that needs flushing and padding. A two-entry queue sits
// between the byte side and the character side, so a byte is accepted
// whenever the queue has room, also while characters wait on a stalled
// output. Sustained rate is set by the single-character output register,
// which must send four characters for every three bytes on long messages.
// After a final byte the group state returns to its start for the next
// message.
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] character,
	output logic       run_last,
	output logic       message_end
);
	import b64e_pkg::*;

	qstat_t qstat;
	job_t   push_job;
	job_t   head_job;
	logic   push;
	logic   pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.qstat      (qstat),
		.push       (push),
		.push_job   (push_job)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.qstat    (qstat)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule

### tb/base64_stream_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// Watches both channels of the encoder, predicts the characters of every
// accepted byte and compares them in order with the characters that leave.
// ----------------------------------------------------------------------------
module base64_stream_encoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [6:0] character,
	input  logic       run_last,
	input  logic       message_end,
	output int         fail_count,
	output int         chars_pending
);
	import b64e_pkg::*;

	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] ch;
		logic       run_last;
		logic       msg_end;
	} b64_char_t;

	b64_char_t   expected_chars[$];
	phase_t      group_phase = PH_FIRST;
	logic [3:0]  leftover = 4'd0;

	initial begin
		fail_count    = 0;
		chars_pending = 0;
	end

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		c = ALPHABET[511 - 8 * v -: 8];
		return c[6:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count = fail_count + 1;
	endtask

	// expected characters of one byte, flags set on the last one
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [6:0] chars [4];
		int         n;
		b64_char_t  e;
		n = 0;
		case (group_phase)
			PH_SECOND: begin
				chars[n] = sextet_char({leftover[1:0], b[7:4]});
				n++;
				leftover    = b[3:0];
				group_phase = PH_THIRD;
				if (fin) begin
					chars[n] = sextet_char({b[3:0], 2'b00});
					n++;
					chars[n] = PAD_CHAR;
					n++;
				end
			end
			PH_THIRD: begin
				chars[n] = sextet_char({leftover, b[7:6]});
				n++;
				chars[n] = sextet_char(b[5:0]);
				n++;
				leftover    = 4'd0;
				group_phase = PH_FIRST;
			end
			default: begin
				chars[n] = sextet_char(b[7:2]);
				n++;
				leftover    = {2'b00, b[1:0]};
				group_phase = PH_SECOND;
				if (fin) begin
					chars[n] = sextet_char({b[1:0], 4'b0000});
					n++;
					chars[n] = PAD_CHAR;
					n++;
					chars[n] = PAD_CHAR;
					n++;
				end
			end
		endcase
		if (fin) begin
			leftover    = 4'd0;
			group_phase = PH_FIRST;
		end
		for (int i = 0; i < n; i++) begin
			e.ch       = chars[i];
			e.run_last = (i == n - 1);
			e.msg_end  = fin && (i == n - 1);
			expected_chars = {expected_chars, e};
		end
	endtask

	always @(posedge clk) begin
		b64_char_t e;
		if (arst_n) begin
			// outputs first, so a character can never match the item of this same edge
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character 0x%02h", character));
				end else begin
					e = expected_chars.pop_front();
					if (character !== e.ch)
						report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
							character, e.ch));
					if (run_last !== e.run_last)
						report_mismatch($sformatf("run_last %b, expected %b on 0x%02h",
							run_last, e.run_last, e.ch));
					if (message_end !== e.msg_end)
						report_mismatch($sformatf("message_end %b, expected %b on 0x%02h",
							message_end, e.msg_end, e.ch));
				end
			end
			if (in_valid && !in_stall)
				encode_byte(data_byte, final_byte);
		end
		chars_pending <= expected_chars.size();
	end

endmodule

### tb/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Feeds directed and random messages into the base64 encoder with random
// gaps and output stalls, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
	import b64e_pkg::*;

	localparam int RANDOM_BYTES = 440;
	localparam int SQUEEZE_HOLD = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [7:0] data_byte   = 8'h00;
	logic       final_byte  = 1'b0;
	logic       out_stall   = 1'b0;
	logic       squeeze_req = 1'b0;
	logic       squeeze_done = 1'b0;
	logic       squeeze_busy = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [6:0] character;
	logic       run_last;
	logic       message_end;
	int         fail_count;
	int         chars_pending;
	int         idle_cycles = 0;
	int         bytes_sent  = 0;
	bit         gapless     = 1'b0;
	logic [7:0] msg_bytes[$];

	base64_stream_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.run_last    (run_last),
		.message_end (message_end)
	);

	base64_stream_encoder_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.character     (character),
		.run_last      (run_last),
		.message_end   (message_end),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// output side: random stalls, quiet stretches, and one long hold-off
	initial begin
		int stall_len;
		int open_len;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				out_stall    <= 1'b1;
				squeeze_busy <= 1'b1;
				repeat (SQUEEZE_HOLD) @(posedge clk);
				out_stall    <= 1'b0;
				squeeze_busy <= 1'b0;
				squeeze_done <= 1'b1;
				@(posedge clk);
			end else begin
				stall_len = pick_gap();
				open_len  = ($urandom_range(9) == 0) ? $urandom_range(60, 30)
					: $urandom_range(4, 1);
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat (open_len) @(posedge clk);
			end
		end
	end

	// called at a clock edge; returns at the edge where the item may change
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		gap = gapless ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	// the checker's count is registered and lags its queue, so step past the current edge first
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0) @(posedge clk);
	endtask

	initial begin
		int len;
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// known vectors, every final phase, all-zero and all-one bytes
		msg_bytes = {8'h4D, 8'h61, 8'h6E};
		send_message();
		msg_bytes = {8'h4D, 8'h61};
		send_message();
		msg_bytes = {8'h4D};
		send_message();
		msg_bytes = {8'h00};
		send_message();
		msg_bytes = {8'hFF};
		send_message();
		msg_bytes = {8'hFF, 8'hFF};
		send_message();
		msg_bytes = {8'hFF, 8'hFF, 8'hFF};
		send_message();
		msg_bytes = {8'h00, 8'h00, 8'h00, 8'h00};
		send_message();
		// sextets 62 and 63 across a group
		msg_bytes = {8'hFB, 8'hEF, 8'hBF};
		send_message();
		wait_drained();

		while (bytes_sent < RANDOM_BYTES) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(6, 1);
			else if (r < 95)
				len = $urandom_range(24, 7);
			else
				len = $urandom_range(60, 25);
			gapless = ($urandom_range(3) == 0);
			if (!squeeze_req && bytes_sent > 150) begin
				// back-to-back items against a long receiver hold-off
				len         = 40;
				gapless     = 1'b1;
				squeeze_req <= 1'b1;
				// start offering only once the hold-off is under way
				in_valid    <= 1'b0;
				@(posedge clk);
				while (!squeeze_busy) @(posedge clk);
			end
			msg_bytes.delete();
			for (int i = 0; i < len; i++)
				msg_bytes = {msg_bytes, 8'($urandom_range(255))};
			send_message();
			bytes_sent = bytes_sent + len;
			if (len == 40 && gapless && squeeze_req)
				wait_drained();
			else if ($urandom_range(9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && chars_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
